@@ hdl/lmsp_pkg.sv @@
// Shared types, codes and constants for the slew-limited motor speed and position loop.
// Depends on nothing; every other file refers to it by scoped names.
package lmsp_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StepW   = 31;
  localparam int unsigned GainW   = 24;
  localparam int unsigned CfgIdxW = 2;

  // opcodes
  localparam logic [1:0] OpTick    = 2'd0;
  localparam logic [1:0] OpLoadVel = 2'd1;
  localparam logic [1:0] OpLoadPos = 2'd2;

  // tick modes
  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeVel  = 2'd1;
  localparam logic [1:0] ModePos  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStepLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPosGain   = 2'd1;

  localparam logic [StepW-1:0] StepLimitRst = 31'd65536;
  localparam logic [GainW-1:0] PosGainRst   = 24'd66;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [1:0]              cmd_mode;
    logic signed [DataW-1:0] target_value;
    logic signed [DataW-1:0] load_value;
  } in_t;

  typedef struct packed {
    logic [StepW-1:0]        drive_magnitude;
    logic                    drive_direction;
    logic signed [DataW-1:0] new_velocity;
  } out_t;

  typedef struct packed {
    logic [StepW-1:0] step_limit;
    logic [GainW-1:0] position_gain;
  } cfg_t;

  // state updates from one processed beat
  typedef struct packed {
    logic                    has_result;
    logic                    vel_we;
    logic signed [DataW-1:0] vel_d;
    logic                    pos_we;
    logic signed [DataW-1:0] pos_d;
    logic                    dir_we;
    logic                    dir_d;
  } upd_t;

endpackage

@@ hdl/accel_limited_motor_speed_position_loop_top.sv @@
// Top level of the slew-limited motor speed controller with proportional position loop.
// Depends on lmsp_pkg, lmsp_cfg_regs and lmsp_datapath.
//
// Takes one beat per clock cycle while the output register is free or being emptied.
// An accepted beat sits in the input register while the single-pass datapath (error
// subtract, 32x24 gain multiply, slew clamp, absolute value) computes it, and its result
// enters the output register at the edge where the beat advances, which a full, unread
// output stalls. The stored velocity is written at that same edge, so back-to-back ticks
// see each other's update.
// Load opcodes and idle ticks produce no result beat. Configuration writes are taken
// every cycle and should only be issued while the block is idle.
module accel_limited_motor_speed_position_loop_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lmsp_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lmsp_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lmsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lmsp_pkg::DataW-1:0]   cfg_data_i
);

  lmsp_pkg::cfg_t cfg;
  lmsp_pkg::upd_t upd;
  lmsp_pkg::out_t res;

  lmsp_pkg::in_t  in_q;
  lmsp_pkg::out_t out_q;
  logic           in_valid_q, in_valid_d;
  logic           out_valid_q, out_valid_d;
  logic signed [lmsp_pkg::DataW-1:0] vel_q, pos_q;
  logic           dir_q;
  logic           in_accept, fire;

  lmsp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lmsp_datapath u_dp (
    .item_i (in_q),
    .cfg_i  (cfg),
    .vel_i  (vel_q),
    .pos_i  (pos_q),
    .dir_i  (dir_q),
    .upd_o  (upd),
    .res_o  (res)
  );

  // advance the held beat when the output slot is free or being emptied
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept)  in_valid_d = 1'b1;
    else if (fire)  in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (fire)             out_valid_d = upd.has_result;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vel_q       <= '0;
      pos_q       <= '0;
      dir_q       <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire && upd.vel_we) vel_q <= upd.vel_d;
      if (fire && upd.pos_we) pos_q <= upd.pos_d;
      if (fire && upd.dir_we) dir_q <= upd.dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) in_q <= in_data_i;
    if (fire && upd.has_result) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/lmsp_cfg_regs.sv @@
// Configuration register file: step limit and position gain.
// Depends on lmsp_pkg.
module lmsp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lmsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lmsp_pkg::DataW-1:0]   cfg_data_i,
  output lmsp_pkg::cfg_t               cfg_o
);

  lmsp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lmsp_pkg::CfgStepLimit: cfg_d.step_limit    = cfg_data_i[lmsp_pkg::StepW-1:0];
        lmsp_pkg::CfgPosGain:   cfg_d.position_gain = cfg_data_i[lmsp_pkg::GainW-1:0];
        default:                cfg_d = cfg_q;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_limit    <= lmsp_pkg::StepLimitRst;
      cfg_q.position_gain <= lmsp_pkg::PosGainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/lmsp_datapath.sv @@
// Single-pass datapath: position error, gain product, slew limit, magnitude and direction.
// Depends on lmsp_pkg; purely combinational, registered by the top level.
module lmsp_datapath (
  input  lmsp_pkg::in_t                     item_i,
  input  lmsp_pkg::cfg_t                    cfg_i,
  input  logic signed [lmsp_pkg::DataW-1:0] vel_i,
  input  logic signed [lmsp_pkg::DataW-1:0] pos_i,
  input  logic                              dir_i,
  output lmsp_pkg::upd_t                    upd_o,
  output lmsp_pkg::out_t                    res_o
);

  localparam logic signed [31:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinVal = 32'sh8000_0000;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF)       sat33 = MaxVal;
    else if (v < -33'sh0_8000_0000) sat33 = MinVal;
    else                            sat33 = v[31:0];
  endfunction

  function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
    if (v > 40'sh00_7FFF_FFFF)       sat40 = MaxVal;
    else if (v < -40'sh00_8000_0000) sat40 = MinVal;
    else                             sat40 = v[31:0];
  endfunction

  logic signed [32:0] err_wide;
  logic signed [31:0] err;
  logic signed [55:0] prod;
  logic signed [31:0] gain_vel;
  logic signed [31:0] want;
  logic signed [32:0] up_wide, dn_wide;
  logic signed [31:0] up_lim, dn_lim;
  logic signed [31:0] nv;
  logic signed [31:0] nv_neg;
  logic               is_tick;

  assign err_wide = 33'(item_i.target_value) - 33'(pos_i);
  assign err      = sat33(err_wide);
  assign prod     = 56'(err) * 56'($signed({1'b0, cfg_i.position_gain}));
  // arithmetic shift of the product floors toward minus infinity
  assign gain_vel = sat40(prod[55:16]);
  assign want     = (item_i.cmd_mode == lmsp_pkg::ModeVel) ? item_i.target_value : gain_vel;

  assign up_wide = 33'(vel_i) + $signed({2'b00, cfg_i.step_limit});
  assign dn_wide = 33'(vel_i) - $signed({2'b00, cfg_i.step_limit});
  assign up_lim  = sat33(up_wide);
  assign dn_lim  = sat33(dn_wide);

  always_comb begin
    if (want > vel_i)      nv = (want > up_lim) ? up_lim : want;
    else if (want < vel_i) nv = (want < dn_lim) ? dn_lim : want;
    else                   nv = vel_i;
  end

  assign nv_neg = -nv;

  assign is_tick = (item_i.opcode == lmsp_pkg::OpTick) &&
                   ((item_i.cmd_mode == lmsp_pkg::ModeVel) ||
                    (item_i.cmd_mode == lmsp_pkg::ModePos));

  always_comb begin
    upd_o            = '0;
    upd_o.vel_d      = nv;
    upd_o.pos_d      = item_i.load_value;
    upd_o.dir_d      = dir_i;
    upd_o.has_result = is_tick;
    upd_o.dir_we     = is_tick;
    upd_o.vel_we     = is_tick;
    case (item_i.opcode)
      lmsp_pkg::OpLoadVel: begin
        upd_o.vel_we = 1'b1;
        upd_o.vel_d  = item_i.load_value;
      end
      lmsp_pkg::OpLoadPos: upd_o.pos_we = 1'b1;
      default: ;
    endcase

    res_o.new_velocity = nv;
    if (nv > 32'sd0) begin
      upd_o.dir_d           = 1'b0;
      res_o.drive_magnitude = nv[30:0];
    end else if (nv < 32'sd0) begin
      upd_o.dir_d           = 1'b1;
      // the most negative value has no positive twin: clamp
      res_o.drive_magnitude = (nv == MinVal) ? MaxVal[30:0] : nv_neg[30:0];
    end else begin
      res_o.drive_magnitude = '0;
    end
    res_o.drive_direction = upd_o.dir_d;
  end

endmodule
